FILE: hdl/camtm_pkg.sv
// ----------------------------------------------------------------------------
// camtm_pkg: shared types and codes of the camera eye/target mover
// Action codes, datapath operation codes and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package camtm_pkg;

   localparam int unsigned ActionWidth = 3;
   localparam int unsigned CoordWidth  = 32;

   localparam logic [ActionWidth-1:0] ACT_FORWARD  = 3'd0;
   localparam logic [ActionWidth-1:0] ACT_STRAFE   = 3'd1;
   localparam logic [ActionWidth-1:0] ACT_VERTICAL = 3'd2;
   localparam logic [ActionWidth-1:0] ACT_TURN     = 3'd3;
   localparam logic [ActionWidth-1:0] ACT_ORBIT    = 3'd4;
   localparam logic [ActionWidth-1:0] ACT_ROLL     = 3'd5;

   localparam logic [CoordWidth-1:0] RESET_EYE_YZ = 32'h0064_0000;

   // Datapath operations.
   localparam logic [3:0] DP_NONE      = 4'd0;
   localparam logic [3:0] DP_CAPTURE   = 4'd1;
   localparam logic [3:0] DP_LOAD      = 4'd2;
   localparam logic [3:0] DP_SHR       = 4'd3;
   localparam logic [3:0] DP_SHL       = 4'd4;
   localparam logic [3:0] DP_SQUARE    = 4'd5;
   localparam logic [3:0] DP_ROOT_INIT = 4'd6;
   localparam logic [3:0] DP_ROOT_STEP = 4'd7;
   localparam logic [3:0] DP_MUL       = 4'd8;
   localparam logic [3:0] DP_DIV_INIT  = 4'd9;
   localparam logic [3:0] DP_DIV_STEP  = 4'd10;
   localparam logic [3:0] DP_STORE     = 4'd11;
   localparam logic [3:0] DP_APPLY     = 4'd12;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic is_move;    // action needs a normalized direction
      logic dir_zero;   // every direction component is zero
      logic too_big;    // largest magnitude is at or above 2^30
      logic too_small;  // largest magnitude is below 2^29
   } status_type;

endpackage

FILE: hdl/camtm_ctrl.sv
// ----------------------------------------------------------------------------
// camtm_ctrl: sequencer of the camera eye/target mover
// Steps the datapath through capture, normalization, square root,
// the three scaled divides and the final update, and owns the result valid.
// ----------------------------------------------------------------------------
module camtm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  camtm_pkg::status_type status,
   output camtm_pkg::cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_PREP  = 4'd1;
   localparam logic [3:0] ST_NORM  = 4'd2;
   localparam logic [3:0] ST_SQ    = 4'd3;
   localparam logic [3:0] ST_RINIT = 4'd4;
   localparam logic [3:0] ST_ROOT  = 4'd5;
   localparam logic [3:0] ST_MUL   = 4'd6;
   localparam logic [3:0] ST_DINIT = 4'd7;
   localparam logic [3:0] ST_DIV   = 4'd8;
   localparam logic [3:0] ST_STORE = 4'd9;
   localparam logic [3:0] ST_APPLY = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.op       = camtm_pkg::DP_NONE;
      cmd.idx      = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = camtm_pkg::DP_CAPTURE;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.op   = camtm_pkg::DP_LOAD;
            state_in = status.is_move ? ST_NORM : ST_APPLY;
         end
         ST_NORM: begin
            if (status.dir_zero) begin
               state_in = ST_APPLY;
            end else if (status.too_big) begin
               cmd.op = camtm_pkg::DP_SHR;
            end else if (status.too_small) begin
               cmd.op = camtm_pkg::DP_SHL;
            end else begin
               idx_in   = 2'd0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            cmd.op = camtm_pkg::DP_SQUARE;
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd2) begin
               state_in = ST_RINIT;
            end
         end
         ST_RINIT: begin
            cmd.op   = camtm_pkg::DP_ROOT_INIT;
            cnt_in   = 5'd0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.op = camtm_pkg::DP_ROOT_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               idx_in   = 2'd0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.op   = camtm_pkg::DP_MUL;
            state_in = ST_DINIT;
         end
         ST_DINIT: begin
            cmd.op   = camtm_pkg::DP_DIV_INIT;
            cnt_in   = 5'd0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = camtm_pkg::DP_DIV_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.op = camtm_pkg::DP_STORE;
            if (idx_ff == 2'd2) begin
               state_in = ST_APPLY;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_APPLY: begin
            // The result register is reloaded only once the previous result is gone.
            if (out_free) begin
               cmd.op       = camtm_pkg::DP_APPLY;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 5'd0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_apply_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == camtm_pkg::DP_APPLY |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while a result is pending");

   a_valid_from_apply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_APPLY)
      else $error("result valid raised outside the update step");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == ST_PREP)
      else $error("accepted transfer did not start processing");

endmodule

FILE: hdl/camtm_dp.sv
// ----------------------------------------------------------------------------
// camtm_dp: datapath of the camera eye/target mover
// Holds eye, target and roll, forms the move direction, normalizes it
// with a bit-serial square root and divider, and updates the points.
// ----------------------------------------------------------------------------
module camtm_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  camtm_pkg::cmd_type    cmd,
   output camtm_pkg::status_type status,
   input  logic [2:0]            in_action,
   input  logic [31:0]           in_step,
   input  logic                  in_hang,
   input  logic [31:0]           in_focus_x,
   input  logic [31:0]           in_focus_y,
   input  logic [31:0]           in_focus_z,
   output logic [223:0]          rsp_data
);

   logic [31:0] eye_ff [3];
   logic [31:0] tgt_ff [3];
   logic [31:0] roll_ff;
   logic [31:0] eye_in [3];
   logic [31:0] tgt_in [3];
   logic [31:0] roll_in;

   logic [2:0]  action_ff;
   logic [31:0] step_ff;
   logic        hang_ff;
   logic [31:0] focus_ff [3];

   logic [32:0] mag_ff [3];
   logic        neg_ff [3];
   logic [31:0] sabs_ff;
   logic        sneg_ff;
   logic [61:0] sum_ff;
   logic [61:0] rx_ff;
   logic [62:0] rr_ff;
   logic [62:0] rbit_ff;
   logic [61:0] prod_ff;
   logic [31:0] rem_ff;
   logic [31:0] quo_ff;
   logic [31:0] mv_ff [3];
   logic [223:0] rsp_ff;

   logic signed [33:0] dvec [3];
   logic signed [33:0] vx, vy;
   logic signed [33:0] cvec [3];
   logic [33:0]  cabs [3];
   logic [32:0]  mmax;
   logic [63:0]  root_try;
   logic [31:0]  div_try;
   logic [31:0]  len;

   function automatic logic signed [33:0] sext(input logic [31:0] v);
      sext = {{2{v[31]}}, v};
   endfunction

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dvec[i] = sext(tgt_ff[i]) - sext(eye_ff[i]);
      end
      vx = sext(eye_ff[0]) - sext(focus_ff[0]);
      vy = sext(eye_ff[1]) - sext(focus_ff[1]);
      case (action_ff)
         camtm_pkg::ACT_FORWARD: begin
            cvec[0] = dvec[0];
            cvec[1] = dvec[1];
            cvec[2] = hang_ff ? 34'sd0 : dvec[2];
         end
         camtm_pkg::ACT_ORBIT: begin
            cvec[0] = vy;
            cvec[1] = -vx;
            cvec[2] = 34'sd0;
         end
         default: begin
            cvec[0] = dvec[1];
            cvec[1] = -dvec[0];
            cvec[2] = 34'sd0;
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         cabs[i] = cvec[i][33] ? 34'(-cvec[i]) : 34'(cvec[i]);
      end
   end

   always_comb begin
      mmax = mag_ff[0];
      if (mag_ff[1] > mmax) mmax = mag_ff[1];
      if (mag_ff[2] > mmax) mmax = mag_ff[2];
      status.is_move   = (action_ff == camtm_pkg::ACT_FORWARD) ||
                         (action_ff == camtm_pkg::ACT_STRAFE) ||
                         (action_ff == camtm_pkg::ACT_TURN) ||
                         (action_ff == camtm_pkg::ACT_ORBIT);
      status.dir_zero  = (mmax == 33'd0);
      status.too_big   = (mmax[32:30] != 3'd0);
      status.too_small = (mmax[32:29] == 4'd0);
   end

   assign root_try = {1'b0, rr_ff} + {1'b0, rbit_ff};
   assign len      = rr_ff[31:0];
   assign div_try  = {rem_ff[30:0], quo_ff[31]};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         eye_in[i] = eye_ff[i];
         tgt_in[i] = tgt_ff[i];
      end
      roll_in = roll_ff;
      case (action_ff)
         camtm_pkg::ACT_FORWARD, camtm_pkg::ACT_STRAFE: begin
            for (int i = 0; i < 3; i++) begin
               eye_in[i] = eye_ff[i] + mv_ff[i];
               tgt_in[i] = tgt_ff[i] + mv_ff[i];
            end
         end
         camtm_pkg::ACT_TURN: begin
            for (int i = 0; i < 3; i++) begin
               tgt_in[i] = tgt_ff[i] + mv_ff[i];
            end
         end
         camtm_pkg::ACT_VERTICAL: begin
            eye_in[2] = eye_ff[2] + step_ff;
            tgt_in[2] = tgt_ff[2] + step_ff;
         end
         camtm_pkg::ACT_ORBIT: begin
            for (int i = 0; i < 3; i++) begin
               eye_in[i] = eye_ff[i] + mv_ff[i];
               tgt_in[i] = focus_ff[i];
            end
         end
         camtm_pkg::ACT_ROLL: begin
            roll_in = roll_ff + step_ff;
         end
         default: begin
            roll_in = roll_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eye_ff[0] <= 32'd0;
         eye_ff[1] <= camtm_pkg::RESET_EYE_YZ;
         eye_ff[2] <= camtm_pkg::RESET_EYE_YZ;
         for (int i = 0; i < 3; i++) begin
            tgt_ff[i] <= 32'd0;
         end
         roll_ff <= 32'd0;
      end else if (cmd.op == camtm_pkg::DP_APPLY) begin
         for (int i = 0; i < 3; i++) begin
            eye_ff[i] <= eye_in[i];
            tgt_ff[i] <= tgt_in[i];
         end
         roll_ff <= roll_in;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         camtm_pkg::DP_CAPTURE: begin
            action_ff   <= in_action;
            step_ff     <= in_step;
            hang_ff     <= in_hang;
            focus_ff[0] <= in_focus_x;
            focus_ff[1] <= in_focus_y;
            focus_ff[2] <= in_focus_z;
         end
         camtm_pkg::DP_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               mag_ff[i] <= cabs[i][32:0];
               neg_ff[i] <= cvec[i][33];
               mv_ff[i]  <= 32'd0;
            end
            sneg_ff <= step_ff[31];
            sabs_ff <= step_ff[31] ? (32'd0 - step_ff) : step_ff;
            sum_ff  <= 62'd0;
         end
         camtm_pkg::DP_SHR: begin
            for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
         end
         camtm_pkg::DP_SHL: begin
            for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 1;
         end
         camtm_pkg::DP_SQUARE: begin
            sum_ff <= sum_ff + 62'(mag_ff[cmd.idx][29:0] * mag_ff[cmd.idx][29:0]);
         end
         camtm_pkg::DP_ROOT_INIT: begin
            rx_ff   <= sum_ff;
            rr_ff   <= 63'd0;
            rbit_ff <= 63'd1 << 62;
         end
         camtm_pkg::DP_ROOT_STEP: begin
            if ({2'b00, rx_ff} >= root_try) begin
               rx_ff <= 62'({2'b00, rx_ff} - root_try);
               rr_ff <= (rr_ff >> 1) + rbit_ff;
            end else begin
               rr_ff <= rr_ff >> 1;
            end
            rbit_ff <= rbit_ff >> 2;
         end
         camtm_pkg::DP_MUL: begin
            prod_ff <= 62'(sabs_ff * mag_ff[cmd.idx][29:0]);
         end
         camtm_pkg::DP_DIV_INIT: begin
            // The quotient fits in 32 bits, so the upper bits start below the divisor.
            rem_ff <= {2'b00, prod_ff[61:32]};
            quo_ff <= prod_ff[31:0];
         end
         camtm_pkg::DP_DIV_STEP: begin
            if (div_try >= len) begin
               rem_ff <= div_try - len;
               quo_ff <= {quo_ff[30:0], 1'b1};
            end else begin
               rem_ff <= div_try;
               quo_ff <= {quo_ff[30:0], 1'b0};
            end
         end
         camtm_pkg::DP_STORE: begin
            mv_ff[cmd.idx] <= (sneg_ff != neg_ff[cmd.idx]) ? (32'd0 - quo_ff) : quo_ff;
         end
         camtm_pkg::DP_APPLY: begin
            rsp_ff <= {roll_in, tgt_in[2], tgt_in[1], tgt_in[0],
                       eye_in[2], eye_in[1], eye_in[0]};
         end
         default: begin
            rsp_ff <= rsp_ff;
         end
      endcase
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: hdl/camera_eye_target_mover.sv
// ----------------------------------------------------------------------------
// camera_eye_target_mover: fly-camera translate, strafe, turn, orbit and roll
// Keeps eye, target and roll in Q16.16 and moves them per command.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_tvalid/req_tready | req_tdata, req_tuser (hang)
//   rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata
//
// Vertical, roll and unknown actions go from the load step straight to the update
// step, and a move with a zero direction goes there after the normalization check.
// Moves along a direction take up to 29 shift
// steps of normalization, 3 squares, 32 square root steps and three
// multiply and 32-step divide passes, all in one shared serial datapath.
// One command is processed at a time; a new one is taken once the update is done.
// A pending result stalls the update step until it is transferred.
// Reset restores eye (0, 100, 100), target (0, 0, 0) and roll 0.
// ----------------------------------------------------------------------------
module camera_eye_target_mover (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // action[2:0], step[34:3], focus_x[66:35], focus_y[98:67], focus_z[130:99]
   input  logic [135:0] req_tdata,
   // hang[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // eye_x_out, eye_y_out, eye_z_out, target_x_out, target_y_out,
   // target_z_out, roll_out, 32 bits each from bit 0 up
   output logic [223:0] rsp_tdata
);

   camtm_pkg::cmd_type    cmd;
   camtm_pkg::status_type status;

   camtm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   camtm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_action  (req_tdata[2:0]),
      .in_step    (req_tdata[34:3]),
      .in_hang    (req_tuser),
      .in_focus_x (req_tdata[66:35]),
      .in_focus_y (req_tdata[98:67]),
      .in_focus_z (req_tdata[130:99]),
      .rsp_data   (rsp_tdata)
   );

endmodule
